// ===== sv/tts_pkg.sv =====
`timescale 1ns / 1ps

package tts_pkg;

    // default sizes of the timer queue
    localparam int QUEUE_DEPTH_DEF = 16;
    localparam int TIME_BITS_DEF   = 48;
    localparam int ID_BITS_DEF     = 8;

    typedef enum logic [2:0] {
        OP_INSERT = 3'd0,
        OP_CANCEL = 3'd1,
        OP_ARM    = 3'd2,
        OP_DISARM = 3'd3,
        OP_TICK   = 3'd4,
        OP_QUERY  = 3'd5
    } opcode_t;

    typedef enum logic [1:0] {
        KIND_STATUS   = 2'd0,
        KIND_PERIODIC = 2'd1,
        KIND_ONESHOT  = 2'd2,
        KIND_WAIT     = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_FULL      = 2'd1,
        ST_NOT_FOUND = 2'd2,
        ST_ZERO_IVL  = 2'd3
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_INS_RD,
        S_INS_CMP,
        S_CAN_RD,
        S_CAN_CMP,
        S_SHF_RD,
        S_SHF_WR,
        S_ARM,
        S_PER_CALC,
        S_PER_UPD,
        S_FIRE_RD,
        S_FIRE_CMP,
        S_QRY_RD,
        S_QRY_WAKE,
        S_QRY_SUB,
        S_EMIT
    } state_t;

    // control part of one result, the data fields travel beside it
    typedef struct packed {
        kind_t   kind;
        status_t status;
        logic    no_timers;
        logic    last;
    } res_ctl_t;

endpackage

// ===== sv/tts_mem.sv =====
`timescale 1ns / 1ps

module tts_mem
    #(
        parameter int DEPTH = 16,
        parameter int WIDTH = 56,
        localparam int AW = $clog2(DEPTH)
    )
    (
        input  logic             clk,
        input  logic             re,
        input  logic             we,
        input  logic [AW-1:0]    addr,
        input  logic [WIDTH-1:0] wdata,
        output logic [WIDTH-1:0] rdata
    );

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== sv/tts_out.sv =====
`timescale 1ns / 1ps

module tts_out
    import tts_pkg::*;
    #(
        parameter int TIME_BITS = TIME_BITS_DEF,
        parameter int ID_BITS   = ID_BITS_DEF
    )
    (
        input  logic                 clk,
        input  logic                 rst_n,
        input  logic                 push,
        input  res_ctl_t             res_ctl,
        input  logic [ID_BITS-1:0]   res_id,
        input  logic [TIME_BITS-1:0] res_wait,
        output logic                 free,
        input  logic                 out_stall,
        output logic                 out_valid,
        output logic [1:0]           kind,
        output logic [ID_BITS-1:0]   fired_id,
        output logic [1:0]           status,
        output logic [TIME_BITS-1:0] wait_us,
        output logic                 no_timers,
        output logic                 last
    );

    logic                 valid_reg;
    logic                 valid_next;
    res_ctl_t             ctl_reg;
    logic [ID_BITS-1:0]   id_reg;
    logic [TIME_BITS-1:0] wait_reg;

    // slot opens when empty or being taken this cycle
    assign free = !valid_reg || !out_stall;

    always_comb
    begin
        if (push)
        begin
            valid_next = 1'b1;
        end
        else
        begin
            valid_next = valid_reg && out_stall;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            ctl_reg  <= res_ctl;
            id_reg   <= res_id;
            wait_reg <= res_wait;
        end
    end

    assign out_valid = valid_reg;
    assign kind      = ctl_reg.kind;
    assign status    = ctl_reg.status;
    assign no_timers = ctl_reg.no_timers;
    assign last      = ctl_reg.last;
    assign fired_id  = id_reg;
    assign wait_us   = wait_reg;

endmodule

// ===== sv/tts_ctrl.sv =====
`timescale 1ns / 1ps

module tts_ctrl
    import tts_pkg::*;
    #(
        parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
        parameter int TIME_BITS   = TIME_BITS_DEF,
        parameter int ID_BITS     = ID_BITS_DEF,
        localparam int IDX_W = $clog2(QUEUE_DEPTH),
        localparam int ENT_W = TIME_BITS + ID_BITS
    )
    (
        input  logic                 clk,
        input  logic                 rst_n,
        input  logic                 in_valid,
        output logic                 in_stall,
        input  logic [2:0]           opcode,
        input  logic [TIME_BITS-1:0] time_us,
        input  logic [ID_BITS-1:0]   task_id,
        input  logic [TIME_BITS-1:0] interval,
        output logic                 mem_re,
        output logic                 mem_we,
        output logic [IDX_W-1:0]     mem_addr,
        output logic [ENT_W-1:0]     mem_wdata,
        input  logic [ENT_W-1:0]     mem_rdata,
        input  logic                 out_free,
        output logic                 emit,
        output res_ctl_t             res_ctl,
        output logic [ID_BITS-1:0]   res_id,
        output logic [TIME_BITS-1:0] res_wait
    );

    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    state_t               state_reg, state_next;
    opcode_t              op_reg, op_next;
    logic [TIME_BITS-1:0] t_reg, t_next;
    logic [ID_BITS-1:0]   id_reg, id_next;
    logic [CNT_W-1:0]     pos_reg, pos_next;
    logic [CNT_W-1:0]     count_reg, count_next;
    logic [IDX_W-1:0]     head_reg, head_next;
    logic                 armed_reg, armed_next;
    logic [TIME_BITS-1:0] pnext_reg, pnext_next;
    status_t              st_reg, st_next;
    logic                 nt_reg, nt_next;
    logic [TIME_BITS-1:0] wake_reg, wake_next;
    logic [TIME_BITS-1:0] s_next_reg, s_next_next;
    logic [TIME_BITS-1:0] s_now_reg, s_now_next;
    logic [TIME_BITS-1:0] diff_reg, diff_next;
    logic                 ge_reg, ge_next;

    logic [TIME_BITS-1:0] rd_time;
    logic [ID_BITS-1:0]   rd_id;
    logic [TIME_BITS:0]   sum_pn;
    logic [TIME_BITS:0]   sum_now;
    logic [TIME_BITS-1:0] sat_pn;
    logic [TIME_BITS-1:0] sat_now;
    logic [CNT_W-1:0]     lidx;
    logic [IDX_W:0]       phys_sum;
    logic [IDX_W-1:0]     head_inc;
    opcode_t              in_op;

    assign in_op   = opcode_t'(opcode);
    assign rd_time = mem_rdata[ENT_W-1:ID_BITS];
    assign rd_id   = mem_rdata[ID_BITS-1:0];
    assign in_stall = (state_reg != S_IDLE);

    // saturating sums
    assign sum_pn  = {1'b0, pnext_reg} + {1'b0, interval};
    assign sum_now = {1'b0, t_reg} + {1'b0, interval};
    assign sat_pn  = sum_pn[TIME_BITS] ? '1 : sum_pn[TIME_BITS-1:0];
    assign sat_now = sum_now[TIME_BITS] ? '1 : sum_now[TIME_BITS-1:0];

    // logical queue position to physical slot, circular from head
    assign phys_sum = {1'b0, head_reg} + {1'b0, lidx[IDX_W-1:0]};
    assign mem_addr = (phys_sum >= (IDX_W+1)'(QUEUE_DEPTH))
                      ? IDX_W'(phys_sum - (IDX_W+1)'(QUEUE_DEPTH))
                      : phys_sum[IDX_W-1:0];
    assign head_inc = (head_reg == IDX_W'(QUEUE_DEPTH - 1)) ? '0 : head_reg + IDX_W'(1);

    always_comb
    begin
        case (state_reg)
            S_INS_RD:   lidx = (pos_reg == '0) ? '0 : pos_reg - CNT_W'(1);
            S_SHF_RD:   lidx = pos_reg + CNT_W'(1);
            S_INS_CMP,
            S_CAN_RD,
            S_CAN_CMP,
            S_SHF_WR:   lidx = pos_reg;
            default:    lidx = '0;
        endcase
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    case (in_op)
                        OP_INSERT:
                            state_next = (count_reg == CNT_W'(QUEUE_DEPTH)) ? S_EMIT : S_INS_RD;
                        OP_CANCEL:
                            state_next = S_CAN_RD;
                        OP_ARM:
                            state_next = (interval == '0) ? S_EMIT : S_ARM;
                        OP_TICK:
                            state_next = armed_reg ? S_PER_CALC : S_FIRE_RD;
                        OP_QUERY:
                            state_next = (!armed_reg && count_reg == '0) ? S_QRY_SUB : S_QRY_RD;
                        default:
                            state_next = S_EMIT;
                    endcase
                end
            end
            S_INS_RD:
                state_next = (pos_reg == '0) ? S_EMIT : S_INS_CMP;
            S_INS_CMP:
                state_next = (rd_time >= t_reg) ? S_INS_RD : S_EMIT;
            S_CAN_RD:
                state_next = (pos_reg == count_reg) ? S_EMIT : S_CAN_CMP;
            S_CAN_CMP:
                state_next = (rd_id == id_reg) ? S_SHF_RD : S_CAN_RD;
            S_SHF_RD:
                state_next = (pos_reg + CNT_W'(1) == count_reg) ? S_EMIT : S_SHF_WR;
            S_SHF_WR:
                state_next = S_SHF_RD;
            S_ARM:
                state_next = S_EMIT;
            S_PER_CALC:
                state_next = S_PER_UPD;
            S_PER_UPD:
            begin
                if (!ge_reg || out_free)
                begin
                    state_next = S_FIRE_RD;
                end
            end
            S_FIRE_RD:
                state_next = (count_reg == '0) ? S_EMIT : S_FIRE_CMP;
            S_FIRE_CMP:
            begin
                if (rd_time >= t_reg)
                begin
                    state_next = S_EMIT;
                end
                else if (out_free)
                begin
                    state_next = S_FIRE_RD;
                end
            end
            S_QRY_RD:
                state_next = (count_reg == '0) ? S_QRY_SUB : S_QRY_WAKE;
            S_QRY_WAKE:
                state_next = S_QRY_SUB;
            S_QRY_SUB,
            S_EMIT:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    // datapath, memory and result outputs
    always_comb
    begin
        op_next     = op_reg;
        t_next      = t_reg;
        id_next     = id_reg;
        pos_next    = pos_reg;
        count_next  = count_reg;
        head_next   = head_reg;
        armed_next  = armed_reg;
        pnext_next  = pnext_reg;
        st_next     = st_reg;
        nt_next     = nt_reg;
        wake_next   = wake_reg;
        s_next_next = s_next_reg;
        s_now_next  = s_now_reg;
        diff_next   = diff_reg;
        ge_next     = ge_reg;
        mem_re      = 1'b0;
        mem_we      = 1'b0;
        mem_wdata   = {t_reg, id_reg};
        emit        = 1'b0;
        res_ctl     = '{kind: KIND_STATUS, status: ST_OK, no_timers: 1'b0, last: 1'b0};
        res_id      = '0;
        res_wait    = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    op_next = in_op;
                    t_next  = time_us;
                    id_next = task_id;
                    st_next = ST_OK;
                    nt_next = 1'b0;
                    case (in_op)
                        OP_INSERT:
                        begin
                            if (count_reg == CNT_W'(QUEUE_DEPTH))
                            begin
                                st_next = ST_FULL;
                            end
                            pos_next = count_reg;
                        end
                        OP_CANCEL:
                            pos_next = '0;
                        OP_ARM:
                        begin
                            if (interval == '0)
                            begin
                                st_next = ST_ZERO_IVL;
                            end
                        end
                        OP_DISARM:
                            armed_next = 1'b0;
                        OP_QUERY:
                            nt_next = !armed_reg && (count_reg == '0);
                        default:
                            st_next = ST_OK;
                    endcase
                end
            end
            S_INS_RD:
            begin
                if (pos_reg == '0)
                begin
                    mem_we     = 1'b1;
                    count_next = count_reg + CNT_W'(1);
                end
                else
                begin
                    mem_re = 1'b1;
                end
            end
            S_INS_CMP:
            begin
                // move entries not earlier than the new one up a slot
                mem_we = 1'b1;
                if (rd_time >= t_reg)
                begin
                    mem_wdata = mem_rdata;
                    pos_next  = pos_reg - CNT_W'(1);
                end
                else
                begin
                    count_next = count_reg + CNT_W'(1);
                end
            end
            S_CAN_RD:
            begin
                if (pos_reg == count_reg)
                begin
                    st_next = ST_NOT_FOUND;
                end
                else
                begin
                    mem_re = 1'b1;
                end
            end
            S_CAN_CMP:
            begin
                if (rd_id != id_reg)
                begin
                    pos_next = pos_reg + CNT_W'(1);
                end
            end
            S_SHF_RD:
            begin
                if (pos_reg + CNT_W'(1) == count_reg)
                begin
                    count_next = count_reg - CNT_W'(1);
                end
                else
                begin
                    mem_re = 1'b1;
                end
            end
            S_SHF_WR:
            begin
                mem_we    = 1'b1;
                mem_wdata = mem_rdata;
                pos_next  = pos_reg + CNT_W'(1);
            end
            S_ARM:
            begin
                armed_next = 1'b1;
                pnext_next = sat_now;
            end
            S_PER_CALC:
            begin
                s_next_next = sat_pn;
                s_now_next  = sat_now;
                diff_next   = pnext_reg - t_reg;
                ge_next     = (t_reg >= pnext_reg);
            end
            S_PER_UPD:
            begin
                if (ge_reg)
                begin
                    if (out_free)
                    begin
                        emit         = 1'b1;
                        res_ctl.kind = KIND_PERIODIC;
                        pnext_next   = (s_next_reg < t_reg) ? s_now_reg : s_next_reg;
                    end
                end
                else if (interval < diff_reg)
                begin
                    // clock went back
                    pnext_next = s_now_reg;
                end
            end
            S_FIRE_RD:
            begin
                if (count_reg != '0)
                begin
                    mem_re = 1'b1;
                end
            end
            S_FIRE_CMP:
            begin
                if (rd_time < t_reg && out_free)
                begin
                    emit         = 1'b1;
                    res_ctl.kind = KIND_ONESHOT;
                    res_id       = rd_id;
                    head_next    = head_inc;
                    count_next   = count_reg - CNT_W'(1);
                end
            end
            S_QRY_RD:
            begin
                if (count_reg == '0)
                begin
                    wake_next = pnext_reg;
                end
                else
                begin
                    mem_re = 1'b1;
                end
            end
            S_QRY_WAKE:
                wake_next = (!armed_reg || rd_time < pnext_reg) ? rd_time : pnext_reg;
            S_QRY_SUB:
            begin
                if (out_free)
                begin
                    emit              = 1'b1;
                    res_ctl.kind      = KIND_WAIT;
                    res_ctl.no_timers = nt_reg;
                    res_ctl.last      = 1'b1;
                    if (!nt_reg && wake_reg > t_reg)
                    begin
                        res_wait = wake_reg - t_reg;
                    end
                end
            end
            S_EMIT:
            begin
                if (out_free)
                begin
                    emit           = 1'b1;
                    res_ctl.status = st_reg;
                    res_ctl.last   = 1'b1;
                end
            end
            default:
                st_next = st_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            head_reg  <= '0;
            armed_reg <= 1'b0;
            pnext_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            head_reg  <= head_next;
            armed_reg <= armed_next;
            pnext_reg <= pnext_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg     <= op_next;
        t_reg      <= t_next;
        id_reg     <= id_next;
        pos_reg    <= pos_next;
        st_reg     <= st_next;
        nt_reg     <= nt_next;
        wake_reg   <= wake_next;
        s_next_reg <= s_next_next;
        s_now_reg  <= s_now_next;
        diff_reg   <= diff_next;
        ge_reg     <= ge_next;
    end

    // op_reg is kept for visibility of the request in flight
    a_op_held: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |=> (op_reg == $past(op_reg)))
        else $error("request opcode changed while in flight");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(QUEUE_DEPTH))
        else $error("queue count beyond depth");

    a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
        emit |-> out_free)
        else $error("result pushed into a busy output slot");

    a_mem_port: assert property (@(posedge clk) disable iff (!rst_n)
        !(mem_re && mem_we))
        else $error("read and write on the queue memory in one cycle");

    a_head_bound: assert property (@(posedge clk) disable iff (!rst_n)
        head_reg <= IDX_W'(QUEUE_DEPTH - 1))
        else $error("queue head out of range");

endmodule

// ===== sv/timer_task_scheduler.sv =====
`timescale 1ns / 1ps
// timer task scheduler: sorted queue of one-shot timers plus one periodic timer
// input channel (in_valid / in_stall): one request per opcode, time_us, task_id;
//   insert, cancel, arm, disarm, tick, query; in_stall stays high while a
//   request is in work, so one request is handled at a time
// output channel (out_valid / out_stall): results with kind, fired_id, status,
//   wait_us, no_timers; last marks the final result of a request
// config channel (cfg_valid / cfg_ready): periodic_interval, write while idle
// queue memory is single ported with a registered read, one read or write a cycle;
//   insert moves each entry not earlier than the new one up a slot, cancel
//   scans for the id and shifts the entries behind it down, tick fires the
//   periodic timer if armed and due, then each overdue one-shot from the head
// reset empties the queue, disarms the periodic timer, clears the interval;
//   queue slots are never read before they are written, so no clearing pass
// a stalled output holds its result; the sequencer waits, nothing is dropped
module timer_task_scheduler
    import tts_pkg::*;
    #(
        parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
        parameter int TIME_BITS   = TIME_BITS_DEF,
        parameter int ID_BITS     = ID_BITS_DEF
    )
    (
        input  logic                 clk,
        input  logic                 rst_n,
        // request channel
        input  logic                 in_valid,
        output logic                 in_stall,
        input  logic [2:0]           opcode,
        input  logic [TIME_BITS-1:0] time_us,
        input  logic [ID_BITS-1:0]   task_id,
        // result channel
        output logic                 out_valid,
        input  logic                 out_stall,
        output logic [1:0]           kind,
        output logic [ID_BITS-1:0]   fired_id,
        output logic [1:0]           status,
        output logic [TIME_BITS-1:0] wait_us,
        output logic                 no_timers,
        output logic                 last,
        // interval register write
        input  logic                 cfg_valid,
        output logic                 cfg_ready,
        input  logic [TIME_BITS-1:0] periodic_interval
    );

    localparam int IDX_W = $clog2(QUEUE_DEPTH);
    localparam int ENT_W = TIME_BITS + ID_BITS;

    logic [TIME_BITS-1:0] ivl_reg;
    logic [TIME_BITS-1:0] ivl_next;

    logic                 mem_re;
    logic                 mem_we;
    logic [IDX_W-1:0]     mem_addr;
    logic [ENT_W-1:0]     mem_wdata;
    logic [ENT_W-1:0]     mem_rdata;

    logic                 out_free;
    logic                 emit;
    res_ctl_t             res_ctl;
    logic [ID_BITS-1:0]   res_id;
    logic [TIME_BITS-1:0] res_wait;

    // interval register, always ready
    assign cfg_ready = 1'b1;

    always_comb
    begin
        ivl_next = ivl_reg;
        if (cfg_valid && cfg_ready)
        begin
            ivl_next = periodic_interval;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ivl_reg <= '0;
        end
        else
        begin
            ivl_reg <= ivl_next;
        end
    end

    // sequencer: decodes requests, walks the queue, runs the periodic timer
    tts_ctrl #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .TIME_BITS   (TIME_BITS),
        .ID_BITS     (ID_BITS)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .opcode    (opcode),
        .time_us   (time_us),
        .task_id   (task_id),
        .interval  (ivl_reg),
        .mem_re    (mem_re),
        .mem_we    (mem_we),
        .mem_addr  (mem_addr),
        .mem_wdata (mem_wdata),
        .mem_rdata (mem_rdata),
        .out_free  (out_free),
        .emit      (emit),
        .res_ctl   (res_ctl),
        .res_id    (res_id),
        .res_wait  (res_wait)
    );

    // queue storage: {due time, id}, circular from the head pointer
    tts_mem #(
        .DEPTH (QUEUE_DEPTH),
        .WIDTH (ENT_W)
    ) u_mem (
        .clk   (clk),
        .re    (mem_re),
        .we    (mem_we),
        .addr  (mem_addr),
        .wdata (mem_wdata),
        .rdata (mem_rdata)
    );

    // result register toward the receiver
    tts_out #(
        .TIME_BITS (TIME_BITS),
        .ID_BITS   (ID_BITS)
    ) u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (emit),
        .res_ctl   (res_ctl),
        .res_id    (res_id),
        .res_wait  (res_wait),
        .free      (out_free),
        .out_stall (out_stall),
        .out_valid (out_valid),
        .kind      (kind),
        .fired_id  (fired_id),
        .status    (status),
        .wait_us   (wait_us),
        .no_timers (no_timers),
        .last      (last)
    );

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps

module tb;
    import tts_pkg::*;

    localparam int TW    = TIME_BITS_DEF;
    localparam int IW    = ID_BITS_DEF;
    localparam int DEPTH = QUEUE_DEPTH_DEF;

    // opcodes the block treats as no-ops
    localparam logic [2:0] OP_SPARE_LO = 3'd6;
    localparam logic [2:0] OP_SPARE_HI = 3'd7;

    // one request as the driver presents it
    typedef struct {
        logic [2:0]    op;
        logic [TW-1:0] t;
        logic [IW-1:0] id;
    } timer_req_t;

    // one result as the block should produce it
    typedef struct {
        kind_t         kind;
        logic [IW-1:0] fired_id;
        status_t       status;
        logic [TW-1:0] wait_us;
        logic          no_timers;
        logic          last;
    } timer_event_t;

    logic          clk = 1'b0;
    logic          rst_n = 1'b0;

    logic          in_valid = 1'b0;
    logic          in_stall;
    logic [2:0]    opcode = '0;
    logic [TW-1:0] time_us = '0;
    logic [IW-1:0] task_id = '0;

    logic          out_valid;
    logic          out_stall = 1'b0;
    logic [1:0]    kind;
    logic [IW-1:0] fired_id;
    logic [1:0]    status;
    logic [TW-1:0] wait_us;
    logic          no_timers;
    logic          last;

    logic          cfg_valid = 1'b0;
    logic          cfg_ready;
    logic [TW-1:0] cfg_interval = '0;

    // requests not yet handed to the block
    timer_req_t    req_queue[$];
    // results the block still owes
    timer_event_t  timer_events[$];

    // shadow copy of the scheduler state
    logic [TW-1:0] slot_time[DEPTH];
    logic [IW-1:0] slot_id[DEPTH];
    int            slot_count = 0;
    logic          per_armed = 1'b0;
    logic [TW-1:0] per_next = '0;
    logic [TW-1:0] period_len = '0;

    int            fail_count = 0;
    bit            no_gaps = 1'b1;
    int            gap_left = 0;
    int            hold_left = 0;
    timer_req_t    next_req;
    timer_event_t  want_ev;

    timer_task_scheduler dut (
        .clk               (clk),
        .rst_n             (rst_n),
        .in_valid          (in_valid),
        .in_stall          (in_stall),
        .opcode            (opcode),
        .time_us           (time_us),
        .task_id           (task_id),
        .out_valid         (out_valid),
        .out_stall         (out_stall),
        .kind              (kind),
        .fired_id          (fired_id),
        .status            (status),
        .wait_us           (wait_us),
        .no_timers         (no_timers),
        .last              (last),
        .cfg_valid         (cfg_valid),
        .cfg_ready         (cfg_ready),
        .periodic_interval (cfg_interval)
    );

    // 2 ns clock
    initial
    begin
        forever #1 clk = ~clk;
    end

    // hard stop in case the block hangs
    initial
    begin
        #1000000;
        $display("timer_task_scheduler verification failed");
        $finish;
    end

    // saturating time sum
    function automatic logic [TW-1:0] sat_sum(logic [TW-1:0] a, logic [TW-1:0] b);
        logic [TW:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[TW] ? {TW{1'b1}} : s[TW-1:0];
    endfunction

    function automatic logic [TW-1:0] rand_time();
        logic [63:0] r;
        r = {$urandom(), $urandom()};
        return r[TW-1:0];
    endfunction

    function automatic void owe_event(kind_t k, logic [IW-1:0] fid, status_t st,
                                      logic [TW-1:0] w, logic nt, logic lst);
        timer_event_t e;
        e.kind      = k;
        e.fired_id  = fid;
        e.status    = st;
        e.wait_us   = w;
        e.no_timers = nt;
        e.last      = lst;
        timer_events.push_back(e);
    endfunction

    // close the gap left by a removed slot
    function automatic void drop_slot(int pos);
        for (int i = pos; i + 1 < slot_count; i++)
        begin
            slot_time[i] = slot_time[i + 1];
            slot_id[i]   = slot_id[i + 1];
        end
        slot_count--;
    endfunction

    // apply one accepted request to the shadow state, queue what it causes
    function automatic void advance_timers(logic [2:0] op, logic [TW-1:0] t,
                                           logic [IW-1:0] id);
        int            pos;
        bit            found;
        logic [TW-1:0] wake;
        pos   = 0;
        found = 1'b0;
        case (op)
            OP_INSERT:
            begin
                if (slot_count >= DEPTH)
                    owe_event(KIND_STATUS, '0, ST_FULL, '0, 1'b0, 1'b1);
                else
                begin
                    // new timer goes before the first slot that is not earlier
                    while (pos < slot_count && slot_time[pos] < t)
                        pos++;
                    for (int j = slot_count; j > pos; j--)
                    begin
                        slot_time[j] = slot_time[j - 1];
                        slot_id[j]   = slot_id[j - 1];
                    end
                    slot_time[pos] = t;
                    slot_id[pos]   = id;
                    slot_count++;
                    owe_event(KIND_STATUS, '0, ST_OK, '0, 1'b0, 1'b1);
                end
            end
            OP_CANCEL:
            begin
                while (!found && pos < slot_count)
                begin
                    if (slot_id[pos] == id)
                    begin
                        drop_slot(pos);
                        found = 1'b1;
                    end
                    else
                        pos++;
                end
                owe_event(KIND_STATUS, '0, found ? ST_OK : ST_NOT_FOUND, '0, 1'b0, 1'b1);
            end
            OP_ARM:
            begin
                if (period_len == '0)
                    owe_event(KIND_STATUS, '0, ST_ZERO_IVL, '0, 1'b0, 1'b1);
                else
                begin
                    per_armed = 1'b1;
                    per_next  = sat_sum(t, period_len);
                    owe_event(KIND_STATUS, '0, ST_OK, '0, 1'b0, 1'b1);
                end
            end
            OP_DISARM:
            begin
                per_armed = 1'b0;
                owe_event(KIND_STATUS, '0, ST_OK, '0, 1'b0, 1'b1);
            end
            OP_TICK:
            begin
                if (per_armed)
                begin
                    if (t >= per_next)
                    begin
                        owe_event(KIND_PERIODIC, '0, ST_OK, '0, 1'b0, 1'b0);
                        per_next = sat_sum(per_next, period_len);
                        // still behind after one period: resync to now
                        if (per_next < t)
                            per_next = sat_sum(t, period_len);
                    end
                    else if (period_len < per_next - t)
                        per_next = sat_sum(t, period_len);   // clock went back
                end
                while (slot_count > 0 && slot_time[0] < t)
                begin
                    owe_event(KIND_ONESHOT, slot_id[0], ST_OK, '0, 1'b0, 1'b0);
                    drop_slot(0);
                end
                owe_event(KIND_STATUS, '0, ST_OK, '0, 1'b0, 1'b1);
            end
            OP_QUERY:
            begin
                if (!per_armed && slot_count == 0)
                    owe_event(KIND_WAIT, '0, ST_OK, '0, 1'b1, 1'b1);
                else
                begin
                    wake = per_next;
                    if (!per_armed || (slot_count > 0 && slot_time[0] < wake))
                        wake = slot_time[0];
                    owe_event(KIND_WAIT, '0, ST_OK, (wake > t) ? wake - t : '0, 1'b0, 1'b1);
                end
            end
            default:
                owe_event(KIND_STATUS, '0, ST_OK, '0, 1'b0, 1'b1);
        endcase
    endfunction

    function automatic void check_field(string name, logic [TW-1:0] want,
                                        logic [TW-1:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
            fail_count++;
        end
    endfunction

    // request driver: random gap before each request, payload held while stalled
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            gap_left = 0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                advance_timers(opcode, time_us, task_id);
                gap_left = no_gaps ? 0 : $urandom_range(0, 11);
            end
            // channel free: either just accepted or idle
            if (!in_valid || !in_stall)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    in_valid <= 1'b0;
                end
                else if (req_queue.size() > 0)
                begin
                    next_req = req_queue.pop_front();
                    in_valid <= 1'b1;
                    opcode   <= next_req.op;
                    time_us  <= next_req.t;
                    task_id  <= next_req.id;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // result monitor: compare against the oldest owed result, stall at random
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            hold_left = 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (timer_events.size() == 0)
                begin
                    $display("%0t: result with no request, expected none, %s %0d id %0h %s %0d %s %0h",
                             $time, "got kind", kind, fired_id, "status", status,
                             "wait", wait_us);
                    fail_count++;
                end
                else
                begin
                    want_ev = timer_events.pop_front();
                    check_field("kind", TW'(want_ev.kind), TW'(kind));
                    check_field("fired_id", TW'(want_ev.fired_id), TW'(fired_id));
                    check_field("status", TW'(want_ev.status), TW'(status));
                    check_field("wait_us", want_ev.wait_us, wait_us);
                    check_field("no_timers", TW'(want_ev.no_timers), TW'(no_timers));
                    check_field("last", TW'(want_ev.last), TW'(last));
                end
                hold_left = no_gaps ? 0 : $urandom_range(0, 11);
            end
            else if (out_valid && hold_left > 0)
                hold_left--;
            out_stall <= (hold_left != 0);
        end
    end

    task automatic push_req(logic [2:0] op, logic [TW-1:0] t, logic [IW-1:0] id);
        timer_req_t r;
        r.op = op;
        r.t  = t;
        r.id = id;
        req_queue.push_back(r);
    endtask

    // interval register write, only while the block is idle
    task automatic write_interval(logic [TW-1:0] v);
        @(posedge clk);
        cfg_valid    <= 1'b1;
        cfg_interval <= v;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid  <= 1'b0;
        period_len = v;
        @(negedge clk);
    endtask

    // wait until every request is taken and every result is back
    task automatic wait_drained();
        @(negedge clk);
        while (req_queue.size() != 0 || in_valid || timer_events.size() != 0)
            @(negedge clk);
    endtask

    // random traffic around a moving current time; filling mode is mostly
    // inserts so the queue runs full and ticks flush long bursts
    task automatic build_random_phase(int n, bit filling, logic [TW-1:0] start);
        logic [TW-1:0] now_us;
        logic [IW-1:0] id;
        int            r;
        now_us = start;
        for (int k = 0; k < n; k++)
        begin
            r  = $urandom_range(0, 99);
            // small id pool so cancels hit
            id = ($urandom_range(0, 4) != 0) ? IW'($urandom_range(0, 15)) : IW'($urandom());
            if (filling)
                r = (r < 78) ? 20 : 70;
            if (r < 5)
                push_req(3'($urandom_range(0, 7)), rand_time(), IW'($urandom()));
            else if (r < 40)
                push_req(OP_INSERT, ($urandom_range(0, 9) == 0) ? rand_time() :
                         now_us + TW'($urandom_range(0, filling ? 3000 : 300)), id);
            else if (r < 50)
                push_req(OP_CANCEL, rand_time(), id);
            else if (r < 57)
                push_req(OP_ARM, now_us, id);
            else if (r < 60)
                push_req(OP_DISARM, rand_time(), id);
            else if (r < 84)
            begin
                // now and then the clock steps back
                if ($urandom_range(0, 11) == 0)
                    now_us = now_us - TW'($urandom_range(1, 800));
                else
                    now_us = now_us + TW'($urandom_range(0, filling ? 2500 : 200));
                push_req(OP_TICK, now_us, id);
            end
            else if (r < 97)
                push_req(OP_QUERY, now_us + TW'($urandom_range(0, 50)), id);
            else
                push_req($urandom_range(0, 1) ? OP_SPARE_HI : OP_SPARE_LO, rand_time(), id);
        end
        // far tick to flush whatever is queued
        if (filling)
            push_req(OP_TICK, now_us + TW'(20000), '0);
    endtask

    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // zero interval, empty scheduler
        write_interval('0);
        push_req(OP_QUERY, '0, '0);           // nothing pending
        push_req(OP_ARM, TW'(5), '0);         // zero interval refused
        push_req(OP_DISARM, '0, '0);          // disarm while not armed
        push_req(OP_CANCEL, '0, IW'(9));      // unknown id
        push_req(OP_TICK, '0, '0);
        push_req(OP_SPARE_LO, '1, '1);
        push_req(OP_SPARE_HI, '0, '0);
        wait_drained();

        write_interval(TW'(1000));
        push_req(OP_INSERT, '1, '1);
        push_req(OP_INSERT, '0, '0);
        push_req(OP_INSERT, TW'(500), IW'(1));
        push_req(OP_INSERT, TW'(500), IW'(2));  // equal time goes ahead
        push_req(OP_QUERY, TW'(100), '0);       // overdue, clamps at zero
        push_req(OP_ARM, TW'(1000), '0);
        push_req(OP_ARM, TW'(2000), '0);        // re-arm while armed
        push_req(OP_TICK, TW'(3000), '0);
        push_req(OP_TICK, TW'(100), '0);        // clock went back
        push_req(OP_QUERY, TW'(200), '0);
        push_req(OP_CANCEL, '0, '1);
        push_req(OP_CANCEL, '0, '1);            // already gone
        push_req(OP_QUERY, TW'(200), '0);
        wait_drained();

        // largest interval, sums saturate
        write_interval('1);
        push_req(OP_ARM, TW'(5), '0);
        push_req(OP_TICK, '1, '0);
        push_req(OP_QUERY, '1, '0);
        wait_drained();

        // interval cleared while armed
        write_interval('0);
        push_req(OP_TICK, TW'(10), '0);
        push_req(OP_TICK, TW'(10), '0);
        push_req(OP_DISARM, '0, '0);
        wait_drained();

        // random phases, first one with no idling at all
        write_interval(TW'($urandom_range(1, 60)));
        build_random_phase(35, 1'b0, TW'($urandom_range(0, 100000)));
        wait_drained();

        write_interval(TW'($urandom_range(1, 60)));
        no_gaps = 1'b0;
        build_random_phase(35, 1'b1, TW'($urandom_range(0, 100000)));
        wait_drained();

        // near the top of the time range
        write_interval('1);
        no_gaps = ($urandom_range(0, 2) == 0);
        build_random_phase(35, 1'b0, {TW{1'b1}} - TW'(3000));
        wait_drained();

        write_interval(rand_time());
        no_gaps = ($urandom_range(0, 2) == 0);
        build_random_phase(35, 1'b0, rand_time());
        wait_drained();

        write_interval('0);
        no_gaps = ($urandom_range(0, 2) == 0);
        build_random_phase(35, 1'b0, TW'($urandom_range(0, 100000)));
        wait_drained();

        write_interval(TW'($urandom_range(1, 5)));
        no_gaps = 1'b0;
        build_random_phase(35, 1'b1, TW'($urandom_range(0, 100000)));
        wait_drained();

        // let any stray result show up
        repeat (30) @(posedge clk);
        if (fail_count == 0 && timer_events.size() == 0)
            $display("timer_task_scheduler verification clean");
        else
            $display("timer_task_scheduler verification failed");
        $finish;
    end

endmodule

// ===== filelist.f =====
sv/tts_pkg.sv
sv/tts_mem.sv
sv/tts_out.sv
sv/tts_ctrl.sv
sv/timer_task_scheduler.sv
tb/tb.sv
